// ===== design/mpts_pkg.sv =====
// shared types and codes for the multi-policy task scheduler
package mpts_pkg;

    localparam int NumSlotsDefault  = 64;
    localparam int CountBitsDefault = 32;
    localparam int KeyBits          = 5;

    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_EMBRYO   = 3'd1;
    localparam logic [2:0] ST_SLEEPING = 3'd2;
    localparam logic [2:0] ST_RUNNABLE = 3'd3;
    localparam logic [2:0] ST_RUNNING  = 3'd4;
    localparam logic [2:0] ST_ZOMBIE   = 3'd5;

    localparam logic [2:0] MODE_ALLOC   = 3'd0;
    localparam logic [2:0] MODE_PICK    = 3'd1;
    localparam logic [2:0] MODE_STATE   = 3'd2;
    localparam logic [2:0] MODE_PRIO    = 3'd3;
    localparam logic [2:0] MODE_QUEUE   = 3'd4;
    localparam logic [2:0] MODE_TICK    = 3'd5;
    localparam logic [2:0] MODE_COLLECT = 3'd6;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NONE  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam logic [2:0] POL_DEFAULT = 3'd0;
    localparam logic [2:0] POL_RR      = 3'd1;
    localparam logic [2:0] POL_PRIO    = 3'd2;
    localparam logic [2:0] POL_INV     = 3'd3;
    localparam logic [2:0] POL_MLQ     = 3'd4;

    localparam logic [2:0] PRIO_MIN  = 3'd1;
    localparam logic [2:0] PRIO_MAX  = 3'd6;
    localparam logic [2:0] QUEUE_MIN = 3'd1;
    localparam logic [2:0] QUEUE_MAX = 3'd4;

    localparam logic [1:0] QUEUE_FIFO_HI = 2'd1;
    localparam logic [1:0] QUEUE_LOW     = 2'd2;
    localparam logic [1:0] QUEUE_HIGH    = 2'd3;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_DPRIO  = 1'b1;

    typedef enum logic [1:0] {
        FIND_ALLOC,
        FIND_PICK,
        FIND_ZOMBIE
    } t_find;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_ALLOC,
        WR_STATE,
        WR_PRIO,
        WR_QUEUE,
        WR_TICK,
        WR_FREE
    } t_wr;

    typedef struct packed {
        t_find       find;
        logic [2:0]  policy;
        logic        target_ok;
        t_wr         wr;
        logic [2:0]  wr_val;
        logic [2:0]  dflt_prio;
        logic [31:0] next_id;
    } t_ctl;

    typedef struct packed {
        logic [2:0] mode;
        logic [5:0] slot;
        logic [2:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  chosen_slot;
        logic [31:0] task_id;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic [31:0] burst;
        logic [2:0]  slot_priority_out;
    } t_out_item;

endpackage

// ===== design/mpts_cell.sv =====
// one task slot: holds the slot state and passes the best candidate to the next cell
module mpts_cell
    import mpts_pkg::*;
#(
    parameter int IDXW       = 6,
    parameter int COUNT_BITS = CountBitsDefault,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl                  i_ctl,
    input  logic [IDXW-1:0]       i_ptr,
    input  logic [IDXW-1:0]       i_target,
    input  logic [IDXW-1:0]       i_wr_idx,
    input  logic                  i_found,
    input  logic [IDXW-1:0]       i_idx,
    input  logic [KeyBits-1:0]    i_key,
    input  logic [31:0]           i_id,
    input  logic [2:0]            i_prio,
    input  logic [COUNT_BITS-1:0] i_sleep,
    input  logic [COUNT_BITS-1:0] i_ready,
    input  logic [COUNT_BITS-1:0] i_run,
    output logic                  o_found,
    output logic [IDXW-1:0]       o_idx,
    output logic [KeyBits-1:0]    o_key,
    output logic [31:0]           o_id,
    output logic [2:0]            o_prio,
    output logic [COUNT_BITS-1:0] o_sleep,
    output logic [COUNT_BITS-1:0] o_ready,
    output logic [COUNT_BITS-1:0] o_run
);

    localparam logic [IDXW-1:0] MyIdx = IDXW'(INDEX);

    logic [2:0]            r_st;
    logic [2:0]            r_prio;
    logic [2:0]            r_queue;
    logic [31:0]           r_id;
    logic [COUNT_BITS-1:0] r_sleep;
    logic [COUNT_BITS-1:0] r_ready;
    logic [COUNT_BITS-1:0] r_run;

    logic                  r_found;
    logic [IDXW-1:0]       r_idx;
    logic [KeyBits-1:0]    r_key;
    logic [31:0]           r_tid;
    logic [2:0]            r_tprio;
    logic [COUNT_BITS-1:0] r_tsleep;
    logic [COUNT_BITS-1:0] r_tready;
    logic [COUNT_BITS-1:0] r_trun;

    logic               elig;
    logic [KeyBits-1:0] key;
    logic               take;
    logic               hit;

    always_comb begin
        elig = 1'b0;
        key  = '0;
        case (i_ctl.find)
            FIND_ALLOC: begin
                elig = (r_st == ST_UNUSED);
            end
            FIND_PICK: begin
                elig = (r_st == ST_RUNNABLE);
                case (i_ctl.policy)
                    POL_PRIO: key = {2'b00, r_prio};
                    POL_INV:  key = {2'b00, ~r_prio};
                    POL_MLQ: begin
                        case (r_queue)
                            3'd1:    key = {QUEUE_FIFO_HI - 2'd1, 3'd0};
                            3'd2:    key = {QUEUE_LOW - 2'd1, r_prio};
                            3'd3:    key = {QUEUE_HIGH - 2'd1, ~r_prio};
                            3'd4:    key = {2'd3, 3'd0};
                            default: elig = 1'b0;
                        endcase
                    end
                    default: key = {4'b0, (MyIdx < i_ptr)};
                endcase
            end
            FIND_ZOMBIE: begin
                elig = (r_st == ST_ZOMBIE) && i_ctl.target_ok && (i_target == MyIdx);
            end
            default: elig = 1'b0;
        endcase
        take = elig && (!i_found || (key < i_key));
        hit  = (i_wr_idx == MyIdx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_UNUSED;
            r_prio  <= '0;
            r_queue <= '0;
            r_id    <= '0;
            r_sleep <= '0;
            r_ready <= '0;
            r_run   <= '0;
            r_found <= 1'b0;
        end else begin
            r_found <= i_found || take;
            case (i_ctl.wr)
                WR_ALLOC: if (hit) begin
                    r_st    <= ST_EMBRYO;
                    r_id    <= i_ctl.next_id;
                    r_prio  <= i_ctl.dflt_prio;
                    r_queue <= '0;
                    r_sleep <= '0;
                    r_ready <= '0;
                    r_run   <= '0;
                end
                WR_STATE: if (hit) r_st <= i_ctl.wr_val;
                WR_PRIO:  if (hit) r_prio <= i_ctl.wr_val;
                WR_QUEUE: if (hit) r_queue <= i_ctl.wr_val;
                WR_FREE: if (hit) begin
                    r_st <= ST_UNUSED;
                    r_id <= '0;
                end
                WR_TICK: begin
                    if (r_st == ST_SLEEPING && !(&r_sleep)) r_sleep <= r_sleep + 1'b1;
                    if (r_st == ST_RUNNABLE && !(&r_ready)) r_ready <= r_ready + 1'b1;
                    if (r_st == ST_RUNNING && !(&r_run)) r_run <= r_run + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_idx    <= MyIdx;
            r_key    <= key;
            r_tid    <= r_id;
            r_tprio  <= r_prio;
            r_tsleep <= r_sleep;
            r_tready <= r_ready;
            r_trun   <= r_run;
        end else begin
            r_idx    <= i_idx;
            r_key    <= i_key;
            r_tid    <= i_id;
            r_tprio  <= i_prio;
            r_tsleep <= i_sleep;
            r_tready <= i_ready;
            r_trun   <= i_run;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_key   = r_key;
    assign o_id    = r_tid;
    assign o_prio  = r_tprio;
    assign o_sleep = r_tsleep;
    assign o_ready = r_tready;
    assign o_run   = r_trun;

endmodule

// ===== design/multi_policy_task_scheduler.sv =====
// top level: control sequencer, config registers and the chain of slot cells
// set state/priority/queue, tick and bad mode go from accept through the apply state to the result
// allocate and pick run the search state before apply; collect runs search, apply and, for a zombie slot, sum
// the search runs one cell per cycle along the slot chain; one item is worked at a time
// a new item is taken while the last result waits for the receiver
// reset: synchronous active low, all slots unused, ids from one, pointer at slot zero
module multi_policy_task_scheduler
    import mpts_pkg::*;
#(
    parameter int NUM_SLOTS  = NumSlotsDefault,
    parameter int COUNT_BITS = CountBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDXW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_APPLY,
        S_SUM
    } t_state;

    t_state      r_state, n_state;
    logic [2:0]  r_mode, n_mode;
    logic [5:0]  r_slot, n_slot;
    logic [2:0]  r_val, n_val;
    logic [2:0]  r_policy, n_policy;
    logic [2:0]  r_dprio, n_dprio;
    logic [31:0] r_next_id, n_next_id;
    logic [IDXW-1:0] r_ptr, n_ptr;
    logic [IDXW-1:0] r_cnt, n_cnt;
    logic [31:0] r_wait, n_wait;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    t_ctl            ctl;
    logic [IDXW-1:0] target;
    logic [IDXW-1:0] wr_idx;
    logic            slot_ok;
    logic            out_free;
    logic            cfg_wr;
    logic [IDXW+5:0] slot_ext;
    logic [IDXW+5:0] idx_ext;

    logic                  c_found [NUM_SLOTS+1];
    logic [IDXW-1:0]       c_idx   [NUM_SLOTS+1];
    logic [KeyBits-1:0]    c_key   [NUM_SLOTS+1];
    logic [31:0]           c_id    [NUM_SLOTS+1];
    logic [2:0]            c_prio  [NUM_SLOTS+1];
    logic [COUNT_BITS-1:0] c_sleep [NUM_SLOTS+1];
    logic [COUNT_BITS-1:0] c_ready [NUM_SLOTS+1];
    logic [COUNT_BITS-1:0] c_run   [NUM_SLOTS+1];

    assign c_found[0] = 1'b0;
    assign c_idx[0]   = '0;
    assign c_key[0]   = '0;
    assign c_id[0]    = '0;
    assign c_prio[0]  = '0;
    assign c_sleep[0] = '0;
    assign c_ready[0] = '0;
    assign c_run[0]   = '0;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        mpts_cell #(
            .IDXW       (IDXW),
            .COUNT_BITS (COUNT_BITS),
            .INDEX      (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_ptr    (r_ptr),
            .i_target (target),
            .i_wr_idx (wr_idx),
            .i_found  (c_found[g]),
            .i_idx    (c_idx[g]),
            .i_key    (c_key[g]),
            .i_id     (c_id[g]),
            .i_prio   (c_prio[g]),
            .i_sleep  (c_sleep[g]),
            .i_ready  (c_ready[g]),
            .i_run    (c_run[g]),
            .o_found  (c_found[g+1]),
            .o_idx    (c_idx[g+1]),
            .o_key    (c_key[g+1]),
            .o_id     (c_id[g+1]),
            .o_prio   (c_prio[g+1]),
            .o_sleep  (c_sleep[g+1]),
            .o_ready  (c_ready[g+1]),
            .o_run    (c_run[g+1])
        );
    end

    assign slot_ext = {{IDXW{1'b0}}, r_slot};
    assign idx_ext  = {6'b0, c_idx[NUM_SLOTS]};
    assign target   = slot_ext[IDXW-1:0];
    assign slot_ok  = ({26'b0, r_slot} < 32'(NUM_SLOTS));
    assign out_free = !r_out_valid || i_out_ready;
    assign cfg_wr   = psel && penable && pwrite;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign pready      = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_POLICY: prdata = {29'b0, r_policy};
            REG_DPRIO:  prdata = {29'b0, r_dprio};
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_slot      = r_slot;
        n_val       = r_val;
        n_policy    = r_policy;
        n_dprio     = r_dprio;
        n_next_id   = r_next_id;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_wait      = r_wait;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        ctl.policy    = r_policy;
        ctl.target_ok = slot_ok;
        ctl.wr        = WR_NONE;
        ctl.wr_val    = r_val;
        ctl.dflt_prio = r_dprio;
        ctl.next_id   = r_next_id;
        wr_idx        = target;
        unique case (r_mode)
            MODE_ALLOC:   ctl.find = FIND_ALLOC;
            MODE_PICK:    ctl.find = FIND_PICK;
            default:      ctl.find = FIND_ZOMBIE;
        endcase

        if (cfg_wr) begin
            unique case (paddr[2])
                REG_POLICY: if (pwdata <= 32'(POL_MLQ)) n_policy = pwdata[2:0];
                REG_DPRIO:  if (pwdata >= 32'(PRIO_MIN) && pwdata <= 32'(PRIO_MAX))
                                n_dprio = pwdata[2:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode = i_in_item.mode;
                    n_slot = i_in_item.slot;
                    n_val  = i_in_item.value;
                    n_cnt  = '0;
                    if (i_in_item.mode == MODE_ALLOC || i_in_item.mode == MODE_PICK ||
                        i_in_item.mode == MODE_COLLECT) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_SEARCH: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == IDXW'(NUM_SLOTS - 1)) n_state = S_APPLY;
            end
            S_APPLY: begin
                if (r_mode == MODE_COLLECT && c_found[NUM_SLOTS]) begin
                    n_wait  = 32'(c_sleep[NUM_SLOTS]) + 32'(c_ready[NUM_SLOTS]);
                    n_state = S_SUM;
                end else if (out_free) begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    case (r_mode)
                        MODE_ALLOC: begin
                            if (c_found[NUM_SLOTS]) begin
                                ctl.wr            = WR_ALLOC;
                                wr_idx            = c_idx[NUM_SLOTS];
                                n_out.chosen_slot = idx_ext[5:0];
                                n_out.task_id     = r_next_id;
                                n_next_id         = r_next_id + 32'd1;
                            end else begin
                                n_out.status = STAT_NONE;
                            end
                        end
                        MODE_PICK: begin
                            if (c_found[NUM_SLOTS]) begin
                                ctl.wr            = WR_STATE;
                                ctl.wr_val        = ST_RUNNING;
                                wr_idx            = c_idx[NUM_SLOTS];
                                n_out.chosen_slot = idx_ext[5:0];
                                n_out.task_id     = c_id[NUM_SLOTS];
                                if (r_policy != POL_PRIO && r_policy != POL_INV &&
                                    r_policy != POL_MLQ) begin
                                    if (c_idx[NUM_SLOTS] == IDXW'(NUM_SLOTS - 1))
                                        n_ptr = '0;
                                    else
                                        n_ptr = c_idx[NUM_SLOTS] + 1'b1;
                                end
                            end else begin
                                n_out.status = STAT_NONE;
                            end
                        end
                        MODE_STATE: begin
                            if (!slot_ok) n_out.status = STAT_NONE;
                            else if (r_val > ST_ZOMBIE) n_out.status = STAT_RANGE;
                            else ctl.wr = WR_STATE;
                        end
                        MODE_PRIO: begin
                            if (!slot_ok) n_out.status = STAT_NONE;
                            else if (r_val < PRIO_MIN || r_val > PRIO_MAX)
                                n_out.status = STAT_RANGE;
                            else ctl.wr = WR_PRIO;
                        end
                        MODE_QUEUE: begin
                            if (!slot_ok) n_out.status = STAT_NONE;
                            else if (r_val < QUEUE_MIN || r_val > QUEUE_MAX)
                                n_out.status = STAT_RANGE;
                            else ctl.wr = WR_QUEUE;
                        end
                        MODE_TICK:    ctl.wr = WR_TICK;
                        MODE_COLLECT: n_out.status = STAT_NONE;
                        default:      n_out.status = STAT_RANGE;
                    endcase
                end
            end
            S_SUM: begin
                if (out_free) begin
                    ctl.wr                  = WR_FREE;
                    wr_idx                  = c_idx[NUM_SLOTS];
                    n_out                   = '0;
                    n_out.task_id           = c_id[NUM_SLOTS];
                    n_out.waiting           = r_wait;
                    n_out.turnaround        = r_wait + 32'(c_run[NUM_SLOTS]);
                    n_out.burst             = 32'(c_run[NUM_SLOTS]);
                    n_out.slot_priority_out = c_prio[NUM_SLOTS];
                    n_out_valid             = 1'b1;
                    n_state                 = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_policy    <= POL_DEFAULT;
            r_dprio     <= 3'd3;
            r_next_id   <= 32'd1;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_TICK;
        end else begin
            r_state     <= n_state;
            r_policy    <= n_policy;
            r_dprio     <= n_dprio;
            r_next_id   <= n_next_id;
            r_ptr       <= n_ptr;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_mode      <= n_mode;
        end
        r_slot <= n_slot;
        r_val  <= n_val;
        r_wait <= n_wait;
        r_out  <= n_out;
    end

endmodule

// ===== test/tb_top.sv =====
// testbench for the multi-policy task scheduler: directed table, random items, predictor check
`timescale 1ns / 100ps
module tb_top;
    import mpts_pkg::*;

    localparam int NSLOT = 64;
    localparam int WATCH_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    multi_policy_task_scheduler DUT (.*);

    always #5 i_clk = ~i_clk;

    // scheduler shadow
    logic [2:0]  sh_policy, sh_dprio;
    logic [2:0]  sh_state [NSLOT];
    logic [2:0]  sh_prio [NSLOT];
    logic [2:0]  sh_queue [NSLOT];
    logic [31:0] sh_id [NSLOT];
    logic [31:0] sh_sleep [NSLOT];
    logic [31:0] sh_ready [NSLOT];
    logic [31:0] sh_run [NSLOT];
    logic [31:0] sh_next_id;
    logic [5:0]  sh_rr;

    t_out_item   expected_q[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          send_idle = 0, recv_idle = 0;
    bit          hold_recv = 0;
    bit          done = 0;

    function automatic int first_ready_in(int q);
        for (int i = 0; i < NSLOT; i++)
            if (sh_state[i] == ST_RUNNABLE && (q < 0 || sh_queue[i] == q)) return i;
        return -1;
    endfunction

    function automatic int extreme_ready_in(int q, bit hi);
        int best;
        best = -1;
        for (int i = 0; i < NSLOT; i++) begin
            if (sh_state[i] != ST_RUNNABLE) continue;
            if (q >= 0 && sh_queue[i] != q) continue;
            if (best < 0 || (hi ? sh_prio[i] > sh_prio[best] : sh_prio[i] < sh_prio[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic int choose_next();
        int s;
        case (sh_policy)
            POL_PRIO: return extreme_ready_in(-1, 0);
            POL_INV:  return extreme_ready_in(-1, 1);
            POL_MLQ: begin
                s = first_ready_in(1);
                if (s < 0) s = extreme_ready_in(2, 0);
                if (s < 0) s = extreme_ready_in(3, 1);
                if (s < 0) s = first_ready_in(4);
                return s;
            end
            default: begin
                for (int k = 0; k < NSLOT; k++) begin
                    s = (sh_rr + k) % NSLOT;
                    if (sh_state[s] == ST_RUNNABLE) begin
                        sh_rr = 6'((s + 1) % NSLOT);
                        return s;
                    end
                end
                return -1;
            end
        endcase
    endfunction

    function automatic logic [31:0] sat_up(logic [31:0] v);
        return (v == '1) ? v : v + 1;
    endfunction

    function automatic t_out_item schedule_op(t_in_item it);
        t_out_item r;
        int s;
        r = '0;
        case (it.mode)
            MODE_ALLOC: begin
                s = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (s < 0 && sh_state[i] == ST_UNUSED) s = i;
                if (s < 0) r.status = STAT_NONE;
                else begin
                    sh_state[s] = ST_EMBRYO;
                    sh_id[s] = sh_next_id;
                    sh_next_id++;
                    sh_prio[s] = sh_dprio;
                    sh_queue[s] = '0;
                    sh_sleep[s] = '0;
                    sh_ready[s] = '0;
                    sh_run[s] = '0;
                    r.chosen_slot = 6'(s);
                    r.task_id = sh_id[s];
                end
            end
            MODE_PICK: begin
                s = choose_next();
                if (s < 0) r.status = STAT_NONE;
                else begin
                    sh_state[s] = ST_RUNNING;
                    r.chosen_slot = 6'(s);
                    r.task_id = sh_id[s];
                end
            end
            MODE_STATE:
                if (it.value > ST_ZOMBIE) r.status = STAT_RANGE;
                else sh_state[it.slot] = it.value;
            MODE_PRIO:
                if (it.value < PRIO_MIN || it.value > PRIO_MAX) r.status = STAT_RANGE;
                else sh_prio[it.slot] = it.value;
            MODE_QUEUE:
                if (it.value < QUEUE_MIN || it.value > QUEUE_MAX) r.status = STAT_RANGE;
                else sh_queue[it.slot] = it.value;
            MODE_TICK:
                for (int i = 0; i < NSLOT; i++) begin
                    if (sh_state[i] == ST_SLEEPING) sh_sleep[i] = sat_up(sh_sleep[i]);
                    else if (sh_state[i] == ST_RUNNABLE) sh_ready[i] = sat_up(sh_ready[i]);
                    else if (sh_state[i] == ST_RUNNING) sh_run[i] = sat_up(sh_run[i]);
                end
            MODE_COLLECT:
                if (sh_state[it.slot] != ST_ZOMBIE) r.status = STAT_NONE;
                else begin
                    r.waiting = sh_sleep[it.slot] + sh_ready[it.slot];
                    r.turnaround = r.waiting + sh_run[it.slot];
                    r.burst = sh_run[it.slot];
                    r.slot_priority_out = sh_prio[it.slot];
                    r.task_id = sh_id[it.slot];
                    sh_id[it.slot] = '0;
                    sh_state[it.slot] = ST_UNUSED;
                end
            default: r.status = STAT_RANGE;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) report_mismatch("unexpected item", 0, 0);
            else begin
                t_out_item e;
                e = expected_q.pop_front();
                if (o_out_item.status !== e.status)
                    report_mismatch("status", o_out_item.status, e.status);
                if (o_out_item.chosen_slot !== e.chosen_slot)
                    report_mismatch("chosen_slot", o_out_item.chosen_slot, e.chosen_slot);
                if (o_out_item.task_id !== e.task_id)
                    report_mismatch("task_id", o_out_item.task_id, e.task_id);
                if (o_out_item.turnaround !== e.turnaround)
                    report_mismatch("turnaround", o_out_item.turnaround, e.turnaround);
                if (o_out_item.waiting !== e.waiting)
                    report_mismatch("waiting", o_out_item.waiting, e.waiting);
                if (o_out_item.burst !== e.burst)
                    report_mismatch("burst", o_out_item.burst, e.burst);
                if (o_out_item.slot_priority_out !== e.slot_priority_out)
                    report_mismatch("slot_priority_out", o_out_item.slot_priority_out,
                                    e.slot_priority_out);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("multi_policy_task_scheduler test failed");
            $finish;
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_recv) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == 3'd0 && data <= 4) sh_policy = data[2:0];
        if (addr == 3'd4 && data >= 1 && data <= 6) sh_dprio = data[2:0];
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (NSLOT + 8) @(posedge i_clk);
    endtask

    task automatic send_item(t_in_item it, bit check_fixed, t_out_item fixed);
        t_out_item p;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        p = schedule_op(it);
        if (check_fixed && p !== fixed) report_mismatch("directed row", p[31:0], fixed[31:0]);
        expected_q.push_back(p);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    function automatic t_in_item mk(logic [2:0] m, logic [5:0] s, logic [2:0] v);
        t_in_item it;
        it.mode = m; it.slot = s; it.value = v;
        return it;
    endfunction

    function automatic t_out_item res(logic [1:0] st, logic [5:0] cs, logic [31:0] id);
        t_out_item r;
        r = '0;
        r.status = st; r.chosen_slot = cs; r.task_id = id;
        return r;
    endfunction

    // random item biased toward a small live population
    function automatic t_in_item rand_item();
        int k;
        logic [5:0] s;
        k = $urandom_range(99);
        s = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(11));
        if (k < 14) return mk(MODE_ALLOC, 6'($urandom), 3'($urandom));
        if (k < 30) return mk(MODE_PICK, 6'($urandom), 3'($urandom));
        if (k < 55) return mk(MODE_STATE, s,
                              ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(2, 5)));
        if (k < 65) return mk(MODE_PRIO, s, 3'($urandom));
        if (k < 74) return mk(MODE_QUEUE, s, 3'($urandom));
        if (k < 86) return mk(MODE_TICK, 6'($urandom), 3'($urandom));
        if (k < 98) return mk(MODE_COLLECT, s, 3'($urandom));
        return mk(3'd7, 6'($urandom), 3'($urandom));
    endfunction

    typedef struct {
        t_in_item  it;
        bit        fixed;
        t_out_item r;
    } t_row;

    initial begin
        t_row rows[$];
        t_out_item none;
        none = '0;
        sh_policy = POL_DEFAULT; sh_dprio = 3'd3; sh_next_id = 1; sh_rr = '0;
        for (int i = 0; i < NSLOT; i++) begin
            sh_state[i] = ST_UNUSED; sh_prio[i] = '0; sh_queue[i] = '0; sh_id[i] = '0;
            sh_sleep[i] = '0; sh_ready[i] = '0; sh_run[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        rows.push_back('{mk(MODE_PICK, 0, 0), 1, res(STAT_NONE, 0, 0)});
        rows.push_back('{mk(MODE_COLLECT, 63, 7), 1, res(STAT_NONE, 0, 0)});
        rows.push_back('{mk(MODE_ALLOC, 0, 0), 1, res(STAT_OK, 0, 1)});
        rows.push_back('{mk(MODE_ALLOC, 63, 7), 1, res(STAT_OK, 1, 2)});
        rows.push_back('{mk(MODE_STATE, 0, 6), 1, res(STAT_RANGE, 0, 0)});
        rows.push_back('{mk(MODE_STATE, 0, 7), 1, res(STAT_RANGE, 0, 0)});
        rows.push_back('{mk(MODE_PRIO, 0, 0), 1, res(STAT_RANGE, 0, 0)});
        rows.push_back('{mk(MODE_PRIO, 0, 7), 1, res(STAT_RANGE, 0, 0)});
        rows.push_back('{mk(MODE_QUEUE, 0, 0), 1, res(STAT_RANGE, 0, 0)});
        rows.push_back('{mk(MODE_QUEUE, 0, 5), 1, res(STAT_RANGE, 0, 0)});
        rows.push_back('{mk(3'd7, 63, 7), 1, res(STAT_RANGE, 0, 0)});
        rows.push_back('{mk(MODE_STATE, 0, ST_RUNNABLE), 1, none});
        rows.push_back('{mk(MODE_STATE, 1, ST_SLEEPING), 1, none});
        rows.push_back('{mk(MODE_PRIO, 1, 6), 1, none});
        rows.push_back('{mk(MODE_QUEUE, 1, 4), 1, none});
        rows.push_back('{mk(MODE_TICK, 0, 0), 1, none});
        rows.push_back('{mk(MODE_PICK, 0, 0), 1, res(STAT_OK, 0, 1)});
        rows.push_back('{mk(MODE_TICK, 0, 0), 0, none});
        rows.push_back('{mk(MODE_STATE, 0, ST_ZOMBIE), 0, none});
        rows.push_back('{mk(MODE_COLLECT, 0, 0), 0, none});
        rows.push_back('{mk(MODE_STATE, 63, ST_ZOMBIE), 0, none});
        rows.push_back('{mk(MODE_COLLECT, 63, 0), 0, none});
        rows.push_back('{mk(MODE_ALLOC, 0, 0), 0, none});
        foreach (rows[i]) send_item(rows[i].it, rows[i].fixed, rows[i].r);
        drain();

        // fill the table to the top
        cfg_write(3'd4, 6);
        for (int i = 0; i < NSLOT + 1; i++) send_item(mk(MODE_ALLOC, 0, 0), 0, none);
        for (int i = 0; i < NSLOT; i++) send_item(mk(MODE_STATE, 6'(i), ST_UNUSED), 0, none);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: begin send_idle = 15; recv_idle = 79; end
                1: begin send_idle = 79; recv_idle = 15; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            cfg_write(3'd0, ph == 5 ? 7 : ph);
            cfg_write(3'd4, ph == 1 ? 1 : ph == 3 ? 0 : $urandom_range(1, 6));
            for (int n = 0; n < 166; n++) begin
                if (ph == 2 && n == 20) begin
                    fork
                        begin
                            hold_recv = 1;
                            repeat (600) @(posedge i_clk);
                            hold_recv = 0;
                        end
                    join_none
                end
                if (ph == 4 && n == 90) begin
                    while (expected_q.size() != 0) @(posedge i_clk);
                end
                send_item(rand_item(), 0, none);
            end
            drain();
        end

        if (errors == 0) $display("multi_policy_task_scheduler test passed");
        else $display("multi_policy_task_scheduler test failed");
        $finish;
    end

endmodule
